/* sv/tfqp_pkg.sv */
`default_nettype none

package tfqp_pkg;

  // Default sizes of the queue and of the item fields.
  localparam int QUEUE_DEPTH_DEF = 48;
  localparam int HANDLE_BITS_DEF = 16;
  localparam int STAMP_BITS_DEF  = 32;

  // Fixed field widths.
  localparam int CLOCK_W = 32;
  localparam int SLACK_W = 20;
  localparam int COUNT_W = 6;
  localparam int OP_W    = 2;

  // Slack after reset is 5 ms, in microseconds.
  localparam logic [SLACK_W-1:0] SLACK_RESET = 20'd5000;
  // Reported counts saturate here.
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 6'd63;

  // Operation codes of an input item. Code 3 is unused and changes nothing.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_PRESENT = 2'd1,
    OP_CLEAR   = 2'd2
  } op_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_PRESENT,
    ST_CLEAR,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // capture the input item and clear the result
    logic push;      // write the item at the tail
    logic evict;     // drop the head entry to make room
    logic pop;       // pop the head entry as a due frame
    logic clear;     // empty the queue
    logic load_out;  // move the finished result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;      // queue holds the maximum number of entries
    logic head_due;  // queue is not empty and its head entry is due
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

/* sv/tfqp_if.sv */
`default_nettype none

// Input channel: one queue operation per item.
interface tfqp_in_if #(
  parameter int HANDLE_BITS = tfqp_pkg::HANDLE_BITS_DEF,
  parameter int STAMP_BITS  = tfqp_pkg::STAMP_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [tfqp_pkg::OP_W-1:0]    op;
  logic [HANDLE_BITS-1:0]       frame_handle;
  logic [STAMP_BITS-1:0]        frame_stamp;
  logic [tfqp_pkg::CLOCK_W-1:0] now_clock;

  modport source (output valid, op, frame_handle, frame_stamp, now_clock, input ready);
  modport sink   (input valid, op, frame_handle, frame_stamp, now_clock, output ready);
endinterface

// Result channel: one result item per input item.
interface tfqp_out_if #(
  parameter int HANDLE_BITS = tfqp_pkg::HANDLE_BITS_DEF,
  parameter int STAMP_BITS  = tfqp_pkg::STAMP_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         shown_valid;
  logic [HANDLE_BITS-1:0]       shown_handle;
  logic [STAMP_BITS-1:0]        shown_stamp;
  logic [tfqp_pkg::COUNT_W-1:0] skipped_count;
  logic                         evicted_valid;
  logic [HANDLE_BITS-1:0]       evicted_handle;
  logic [tfqp_pkg::COUNT_W-1:0] queue_count;

  modport source (output valid, shown_valid, shown_handle, shown_stamp, skipped_count,
                  evicted_valid, evicted_handle, queue_count, input ready);
  modport sink   (input valid, shown_valid, shown_handle, shown_stamp, skipped_count,
                  evicted_valid, evicted_handle, queue_count, output ready);
endinterface

// Configuration channel: writes the due slack register.
interface tfqp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tfqp_pkg::SLACK_W-1:0] due_slack;

  modport source (output valid, due_slack, input ready);
  modport sink   (input valid, due_slack, output ready);
endinterface

`default_nettype wire

/* sv/timestamped_frame_queue_presenter_top.sv */
// A push or a clear runs its own state, then finish loads the result into the output
//   register; a present pops its due entries first; an unused op goes right to finish.
// The next item is taken as a result is handed over, which waits for a free output; the
//   present walk pops one entry per cycle through the registered read of the store.
// Reset (rst_n, synchronous, active low): queue empty, head and tail at zero, slack 5000,
//   no result pending; the entry store is not cleared and needs no time after reset.
`default_nettype none

module timestamped_frame_queue_presenter_top #(
  parameter int QUEUE_DEPTH = tfqp_pkg::QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = tfqp_pkg::HANDLE_BITS_DEF,
  parameter int STAMP_BITS  = tfqp_pkg::STAMP_BITS_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  tfqp_in_if.sink     in_chan,
  tfqp_out_if.source  out_chan,
  tfqp_cfg_if.sink    cfg_chan
);

  tfqp_pkg::dp_cmd_t  cmd;
  tfqp_pkg::dp_stat_t stat;
  logic               in_ready;

  // The slack register takes a write in any cycle.
  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = in_ready;

  // Sequencer for push, present walk, clear and result handover.
  tfqp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_op    (in_chan.op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Entry store, ring pointers, due compare and output register.
  tfqp_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS),
    .STAMP_BITS  (STAMP_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .frame_handle   (in_chan.frame_handle),
    .frame_stamp    (in_chan.frame_stamp),
    .now_clock      (in_chan.now_clock),
    .cfg_valid      (cfg_chan.valid),
    .cfg_due_slack  (cfg_chan.due_slack),
    .out_ready      (out_chan.ready),
    .out_valid      (out_chan.valid),
    .shown_valid    (out_chan.shown_valid),
    .shown_handle   (out_chan.shown_handle),
    .shown_stamp    (out_chan.shown_stamp),
    .skipped_count  (out_chan.skipped_count),
    .evicted_valid  (out_chan.evicted_valid),
    .evicted_handle (out_chan.evicted_handle),
    .queue_count    (out_chan.queue_count)
  );

endmodule

`default_nettype wire

/* sv/tfqp_ctrl.sv */
`default_nettype none

module tfqp_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [tfqp_pkg::OP_W-1:0] in_op,
  output logic                           in_ready,
  input  wire tfqp_pkg::dp_stat_t        stat,
  output tfqp_pkg::dp_cmd_t              cmd
);

  tfqp_pkg::state_t state_r;
  tfqp_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfqp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;

    case (state_r)
      tfqp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      tfqp_pkg::ST_PUSH: begin
        cmd.push  = 1'b1;
        cmd.evict = stat.full;
        state_nxt = tfqp_pkg::ST_FINISH;
      end
      tfqp_pkg::ST_PRESENT: begin
        // Pop one due entry per cycle; stop at the first entry that is not due.
        if (stat.head_due) begin
          cmd.pop = 1'b1;
        end else begin
          state_nxt = tfqp_pkg::ST_FINISH;
        end
      end
      tfqp_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = tfqp_pkg::ST_FINISH;
      end
      tfqp_pkg::ST_FINISH: begin
        // Hand the result over, and take the next item in the same cycle.
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          in_ready     = 1'b1;
          state_nxt    = tfqp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tfqp_pkg::ST_IDLE;
      end
    endcase

    // Dispatch an accepted item by its operation.
    if (in_ready && in_valid) begin
      cmd.accept = 1'b1;
      case (in_op)
        tfqp_pkg::OP_PUSH:    state_nxt = tfqp_pkg::ST_PUSH;
        tfqp_pkg::OP_PRESENT: state_nxt = tfqp_pkg::ST_PRESENT;
        tfqp_pkg::OP_CLEAR:   state_nxt = tfqp_pkg::ST_CLEAR;
        default:              state_nxt = tfqp_pkg::ST_FINISH;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/tfqp_dp.sv */
`default_nettype none

module tfqp_dp #(
  parameter int QUEUE_DEPTH = tfqp_pkg::QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = tfqp_pkg::HANDLE_BITS_DEF,
  parameter int STAMP_BITS  = tfqp_pkg::STAMP_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tfqp_pkg::dp_cmd_t               cmd,
  output tfqp_pkg::dp_stat_t                   stat,
  input  wire logic [HANDLE_BITS-1:0]          frame_handle,
  input  wire logic [STAMP_BITS-1:0]           frame_stamp,
  input  wire logic [tfqp_pkg::CLOCK_W-1:0]    now_clock,
  input  wire logic                            cfg_valid,
  input  wire logic [tfqp_pkg::SLACK_W-1:0]    cfg_due_slack,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic                                 shown_valid,
  output logic [HANDLE_BITS-1:0]               shown_handle,
  output logic [STAMP_BITS-1:0]                shown_stamp,
  output logic [tfqp_pkg::COUNT_W-1:0]         skipped_count,
  output logic                                 evicted_valid,
  output logic [HANDLE_BITS-1:0]               evicted_handle,
  output logic [tfqp_pkg::COUNT_W-1:0]         queue_count
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  // Deadline is wide enough for the larger operand plus a carry, so it never wraps.
  localparam int DL_W  = ((STAMP_BITS > tfqp_pkg::CLOCK_W) ? STAMP_BITS : tfqp_pkg::CLOCK_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  // Entry storage.
  logic [HANDLE_BITS-1:0] handle_mem [QUEUE_DEPTH];
  logic [STAMP_BITS-1:0]  stamp_mem  [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] rd_handle_r;
  logic [STAMP_BITS-1:0]  rd_stamp_r;
  logic [IDX_W-1:0]       rd_addr;

  // Ring pointers and fill count.
  logic [IDX_W-1:0] head_r, head_nxt, head_inc;
  logic [IDX_W-1:0] tail_r, tail_nxt, tail_inc;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [tfqp_pkg::COUNT_W-1:0] count_sat;

  // Configuration.
  logic [tfqp_pkg::SLACK_W-1:0] slack_r;

  // Captured item.
  logic [HANDLE_BITS-1:0] item_handle_r;
  logic [STAMP_BITS-1:0]  item_stamp_r;
  logic [DL_W-1:0]        deadline_r;
  logic                   head_due;

  // Result being built.
  logic                          sv_r;
  logic [HANDLE_BITS-1:0]        sh_r;
  logic [STAMP_BITS-1:0]         ss_r;
  logic [tfqp_pkg::COUNT_W-1:0]  sk_r;
  logic                          ev_r;
  logic [HANDLE_BITS-1:0]        eh_r;

  // Output register.
  logic                          out_valid_r;
  logic                          o_sv_r;
  logic [HANDLE_BITS-1:0]        o_sh_r;
  logic [STAMP_BITS-1:0]         o_ss_r;
  logic [tfqp_pkg::COUNT_W-1:0]  o_sk_r;
  logic                          o_ev_r;
  logic [HANDLE_BITS-1:0]        o_eh_r;
  logic [tfqp_pkg::COUNT_W-1:0]  o_qc_r;

  // Pointer increments with wrap at the queue depth.
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;

  // The fill count as reported, saturated to the field width.
  assign count_sat = (32'(count_r) > 32'(tfqp_pkg::COUNT_MAX)) ?
                     tfqp_pkg::COUNT_MAX : tfqp_pkg::COUNT_W'(count_r);

  // Pointer and count updates.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else begin
      if (cmd.evict || cmd.pop) begin
        head_nxt = head_inc;
      end
      if (cmd.push) begin
        tail_nxt = tail_inc;
      end
      if (cmd.pop) begin
        count_nxt = count_r - 1'b1;
      end else if (cmd.push && !cmd.evict) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // The read port follows the head every cycle, so the head entry is ready
  // in the cycle after the head moves; a pop reads ahead to the next entry.
  assign rd_addr = cmd.pop ? head_inc : head_r;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      handle_mem[tail_r] <= item_handle_r;
      stamp_mem[tail_r]  <= item_stamp_r;
    end
    rd_handle_r <= handle_mem[rd_addr];
    rd_stamp_r  <= stamp_mem[rd_addr];
  end

  // Slack register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slack_r <= tfqp_pkg::SLACK_RESET;
    end else if (cfg_valid) begin
      slack_r <= cfg_due_slack;
    end
  end

  // Capture the item; the due deadline is clock plus slack, computed once.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_handle_r <= frame_handle;
      item_stamp_r  <= frame_stamp;
      deadline_r    <= DL_W'(now_clock) + DL_W'(slack_r);
    end
  end

  // The head entry is due when its stamp is at most the deadline.
  assign head_due = (count_r != '0) && (DL_W'(rd_stamp_r) <= deadline_r);

  // Build the result as the operation runs.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sv_r <= 1'b0;
      sh_r <= '0;
      ss_r <= '0;
      sk_r <= '0;
      ev_r <= 1'b0;
      eh_r <= '0;
    end else begin
      if (cmd.evict) begin
        ev_r <= 1'b1;
        eh_r <= rd_handle_r;
      end
      if (cmd.pop) begin
        // Each pop after the first one skips the frame popped before it.
        sv_r <= 1'b1;
        sh_r <= rd_handle_r;
        ss_r <= rd_stamp_r;
        if (sv_r && (sk_r != tfqp_pkg::COUNT_MAX)) begin
          sk_r <= sk_r + 1'b1;
        end
      end
      if (cmd.clear) begin
        sk_r <= count_sat;
      end
    end
  end

  // Output register, so that a waiting result does not hold up the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_sv_r <= sv_r;
      o_sh_r <= sh_r;
      o_ss_r <= ss_r;
      o_sk_r <= sk_r;
      o_ev_r <= ev_r;
      o_eh_r <= eh_r;
      o_qc_r <= count_sat;
    end
  end

  // Status to the controller.
  assign stat.full     = (count_r >= FULL_CNT);
  assign stat.head_due = head_due;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign shown_valid    = o_sv_r;
  assign shown_handle   = o_sh_r;
  assign shown_stamp    = o_ss_r;
  assign skipped_count  = o_sk_r;
  assign evicted_valid  = o_ev_r;
  assign evicted_handle = o_eh_r;
  assign queue_count    = o_qc_r;

endmodule

`default_nettype wire

/* sv/tfqp_checker.sv */
`default_nettype none

module tfqp_checker #(
  parameter int QUEUE_DEPTH = tfqp_pkg::QUEUE_DEPTH_DEF,
  parameter int HANDLE_BITS = tfqp_pkg::HANDLE_BITS_DEF,
  parameter int STAMP_BITS  = tfqp_pkg::STAMP_BITS_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          shown_valid,
  input wire logic [HANDLE_BITS-1:0]        shown_handle,
  input wire logic [STAMP_BITS-1:0]         shown_stamp,
  input wire logic [tfqp_pkg::COUNT_W-1:0]  skipped_count,
  input wire logic                          evicted_valid,
  input wire logic [HANDLE_BITS-1:0]        evicted_handle,
  input wire logic [tfqp_pkg::COUNT_W-1:0]  queue_count
);

  localparam logic [tfqp_pkg::COUNT_W-1:0] FULL_SAT =
    (QUEUE_DEPTH > 63) ? tfqp_pkg::COUNT_MAX : tfqp_pkg::COUNT_W'(QUEUE_DEPTH);

  // A result that waits stays valid and keeps its handles, stamp and counts.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(shown_handle) && $stable(shown_stamp)
      && $stable(skipped_count) && $stable(queue_count) && $stable(evicted_handle))
    else $error("result changed while stalled");

  // Reset drops any pending result and leaves the input open.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // An eviction only happens on a push into a full queue, which stays full.
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && evicted_valid |-> queue_count == FULL_SAT && !shown_valid
      && skipped_count == '0)
    else $error("eviction reported without a full queue");

  // Fields of a frame not shown or not evicted read as zero.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (shown_valid || (shown_handle == '0 && shown_stamp == '0))
      && (evicted_valid || evicted_handle == '0))
    else $error("unused result field is not zero");

endmodule

bind timestamped_frame_queue_presenter_top tfqp_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .HANDLE_BITS (HANDLE_BITS),
  .STAMP_BITS  (STAMP_BITS)
) u_tfqp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .shown_valid    (out_chan.shown_valid),
  .shown_handle   (out_chan.shown_handle),
  .shown_stamp    (out_chan.shown_stamp),
  .skipped_count  (out_chan.skipped_count),
  .evicted_valid  (out_chan.evicted_valid),
  .evicted_handle (out_chan.evicted_handle),
  .queue_count    (out_chan.queue_count)
);

`default_nettype wire
